>>> rtl/cfss_pkg.sv
// Package for the case-folded substring search block.
// Holds the transaction codes, folding constants, cell control struct and the
// case-folding function. Depends on nothing.
package cfss_pkg;

   // Request kinds
   localparam logic REQ_PATTERN = 1'b0;
   localparam logic REQ_TEXT    = 1'b1;

   // Result kinds
   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_NONE  = 1'b1;

   // Case folding: lower-case ASCII letters move down to upper case
   localparam logic [7:0] FOLD_LOW    = 8'd97;
   localparam logic [7:0] FOLD_HIGH   = 8'd122;
   localparam logic [7:0] FOLD_OFFSET = 8'd32;

   localparam int         POS_W   = 16;
   localparam int         POS_MAX = 65535;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic       shift;  // text character steps the match chain
      logic       flush;  // final text character: clear partial matches
      logic       load;   // pattern character is written
      logic [7:0] ch;     // folded character
   } cfss_ctl_type;

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b inside {[FOLD_LOW:FOLD_HIGH]}) begin
         r = b - FOLD_OFFSET;
      end
      return r;
   endfunction

endpackage

>>> rtl/cfss_if.sv
// Valid/ready channel interfaces for the request and response transactions.
// No dependencies.
interface cfss_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output req_type, output ch, output last, input ready);
   modport sink   (input valid, input req_type, input ch, input last, output ready);
endinterface

interface cfss_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] position;
   logic        end_of_run;

   modport source (output valid, output kind, output position, output end_of_run, input ready);
   modport sink   (input valid, input kind, input position, input end_of_run, output ready);
endinterface

>>> rtl/case_folded_substring_search.sv
// Case-folded substring search: a row of match cells and the run sequencer.
// Depends on cfss_pkg, cfss_if and cfss_cell.
//
// Usage: send pattern characters on req_port with req_type = 0; last closes the
// pattern. Then stream text characters with req_type = 1; last ends the run.
// Letters a-z are folded to upper case on both sides before comparing.
// Each occurrence yields a response with kind = 0 and the 1-based start
// position (saturating at 65535); a run with no occurrence ends with one
// response of kind = 1 and position 0. end_of_run marks a response
// caused by the final text character. A pattern character after the pattern
// is closed starts a new pattern and abandons the run in progress.
// Throughput: one transaction per cycle on either channel; every cell compares
// its pattern character with the broadcast text character in the same cycle.
// The response is registered and appears in the cycle after acceptance.
// When rsp_port stalls, the response is held and req_port.ready drops until it
// is taken. Reset clears the pattern length, run state and partial matches at
// once; pattern characters are kept in the cells and need no clearing pass.
module case_folded_substring_search import cfss_pkg::*; #(
   parameter int MAX_PATTERN = 256
) (
   input  logic        clock,
   input  logic        reset,
   cfss_req_if.sink    req_port,
   cfss_rsp_if.source  rsp_port
);

   localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
   localparam int COUNT_CAP = 65535 + MAX_PATTERN;
   localparam int COUNT_W   = $clog2(COUNT_CAP + 1);

   logic [LEN_W-1:0]   len_ff, len_in;
   logic               closed_ff, closed_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff, kind_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               eor_ff, eor_in;

   logic               accept;
   logic               pat_acc;
   logic               restart;
   logic [LEN_W-1:0]   eff_len;
   logic               hit;
   logic               emit;
   logic [COUNT_W-1:0] count_new;
   logic [COUNT_W-1:0] start_pos;
   logic [POS_W-1:0]   start_sat;
   cfss_ctl_type       ctl;

   logic [MAX_PATTERN:0]   match_link;
   logic [MAX_PATTERN-1:0] hits;

   // Accept while the response slot is free or being drained
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;

   // Decode the transaction
   assign pat_acc = accept && (req_port.req_type == REQ_PATTERN);
   assign restart = pat_acc && closed_ff;
   assign eff_len = restart ? '0 : len_ff;

   always_comb begin
      ctl.ch    = fold_case(req_port.ch);
      ctl.flush = req_port.last;
      ctl.load  = pat_acc && (eff_len < LEN_W'(MAX_PATTERN));
      ctl.shift = accept && (req_port.req_type == REQ_TEXT) && closed_ff && (len_ff != '0);
   end

   // Chain of cells: each extends its neighbour's partial match
   assign match_link[0] = 1'b1;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      cfss_cell #(
         .INDEX (j),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_len     (eff_len),
         .match_prev (match_link[j]),
         .match_next (match_link[j+1]),
         .hit        (hits[j])
      );
   end

   // Only the cell holding the final pattern character can report a hit
   assign hit = |hits;

   // Start position of the occurrence, saturated to the response width
   assign count_new = (count_ff < COUNT_W'(COUNT_CAP)) ? count_ff + 1'b1 : count_ff;
   assign start_pos = count_new - COUNT_W'(len_ff) + 1'b1;
   assign start_sat = (start_pos > COUNT_W'(POS_MAX)) ? POS_W'(POS_MAX)
                                                      : start_pos[POS_W-1:0];

   assign emit = ctl.shift && (hit || (ctl.flush && !found_ff));

   // Pattern length and close flag
   always_comb begin
      len_in    = len_ff;
      closed_in = closed_ff;
      if (pat_acc) begin
         len_in    = ctl.load ? eff_len + 1'b1 : eff_len;
         closed_in = req_port.last;
      end
   end

   // Run counters: reset on a new pattern or at the end of a run
   always_comb begin
      count_in = count_ff;
      found_in = found_ff;
      if (restart) begin
         count_in = '0;
         found_in = 1'b0;
      end else if (ctl.shift) begin
         count_in = ctl.flush ? '0 : count_new;
         found_in = ctl.flush ? 1'b0 : (found_ff || hit);
      end
   end

   // Response register: load on emit, drop when taken, hold otherwise
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      eor_in       = eor_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = hit ? KIND_MATCH : KIND_NONE;
         pos_in       = hit ? start_sat : '0;
         eor_in       = ctl.flush;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         closed_ff    <= 1'b0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         closed_ff    <= closed_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pos_ff  <= pos_in;
      eor_ff  <= eor_in;
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.kind       = kind_ff;
   assign rsp_port.position   = pos_ff;
   assign rsp_port.end_of_run = eor_ff;

endmodule

>>> rtl/cfss_cell.sv
// One cell of the match chain: holds one pattern character and the partial
// match bit that ends at this position. Depends on cfss_pkg.
module cfss_cell import cfss_pkg::*; #(
   parameter int INDEX = 0,
   parameter int LEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  cfss_ctl_type     ctl,
   input  logic [LEN_W-1:0] wr_len,
   input  logic             match_prev,
   output logic             match_next,
   output logic             hit
);

   logic [7:0] pat_ff, pat_in;
   logic       last_ff, last_in;
   logic       match_ff, match_in;
   logic       sel;
   logic       match_new;

   // Compare the broadcast character and extend the neighbour's partial match
   assign sel       = (wr_len == LEN_W'(INDEX));
   assign match_new = match_prev & (pat_ff == ctl.ch);
   assign hit       = ctl.shift & match_new & last_ff;
   assign match_next = match_ff;
   assign pat_in    = ctl.ch;

   // Advance, drop or hold the partial match
   always_comb begin
      if (ctl.load) begin
         match_in = 1'b0;
      end else if (ctl.shift) begin
         match_in = ctl.flush ? 1'b0 : match_new;
      end else begin
         match_in = match_ff;
      end
   end

   // Mark the cell that holds the final pattern character
   always_comb begin
      last_in = ctl.load ? sel : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         match_ff <= match_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load && sel) begin
         pat_ff <= pat_in;
      end
   end

endmodule

>>> rtl/cfss_checker.sv
// Port-level checks for the case-folded substring search top level.
// Depends on cfss_pkg; bound to case_folded_substring_search below.
module cfss_checker import cfss_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_req_type,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [15:0] rsp_position,
   input logic        rsp_end_of_run
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
                                  && $stable(rsp_kind) && $stable(rsp_end_of_run))
      else $error("stalled response changed");

   // A no-occurrence result closes the run and carries position zero
   a_none_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_NONE) |-> (rsp_position == 16'd0) && rsp_end_of_run)
      else $error("malformed no-occurrence result");

   // Match positions are 1-based
   a_match_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_MATCH) |-> (rsp_position != 16'd0))
      else $error("match reported at position zero");

   // A pattern transaction never causes a response
   a_pattern_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_req_type == REQ_PATTERN) && !(rsp_valid && !rsp_ready)
      |=> !rsp_valid)
      else $error("response after pattern character");

   // Nothing is pending after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind case_folded_substring_search cfss_checker u_cfss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .req_req_type   (req_port.req_type),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_kind       (rsp_port.kind),
   .rsp_position   (rsp_port.position),
   .rsp_end_of_run (rsp_port.end_of_run)
);

>>> dv/cfss_search_checker.sv
`timescale 1ns / 1ps
// Checker for the case-folded substring search: predicts responses from the
// accepted request transactions and compares each accepted response in order.
// Depends on cfss_pkg and the channel interfaces in cfss_if.
module cfss_search_checker import cfss_pkg::*; #(
   parameter int MAX_PATTERN = 256
) (
   input  logic  clock,
   input  logic  reset,
   cfss_req_if   req_mon,
   cfss_rsp_if   rsp_mon,
   output int    error_count,
   output int    pending
);

   typedef struct packed {
      logic              kind;
      logic [POS_W-1:0]  position;
      logic              end_of_run;
   } search_hit_type;

   // Text count stops here so that start positions stay exact up to POS_MAX
   localparam int COUNT_CAP = POS_MAX + MAX_PATTERN;

   logic [7:0]     pattern_chars [MAX_PATTERN];
   int             pattern_len;
   bit             pattern_done;
   logic [7:0]     recent_text [$];   // index 0 is the newest text character
   int             text_seen;
   bit             run_hit;
   search_hit_type expected_hits [$];

   function automatic logic [7:0] upper_case(input logic [7:0] b);
      return (b >= FOLD_LOW && b <= FOLD_HIGH) ? b - FOLD_OFFSET : b;
   endfunction

   // Advance the search state by one request and queue the responses it causes
   task automatic search_step(input logic kind, input logic [7:0] raw, input logic fin);
      logic [7:0] c;
      bit         hit;
      int         start;
      c = upper_case(raw);
      if (kind == REQ_PATTERN) begin
         // a pattern character after close starts afresh and drops the run
         if (pattern_done) begin
            pattern_done = 1'b0;
            pattern_len  = 0;
            text_seen    = 0;
            run_hit      = 1'b0;
         end
         if (pattern_len < MAX_PATTERN) begin
            pattern_chars[pattern_len] = c;
            pattern_len++;
         end
         if (fin) begin
            pattern_done = 1'b1;
         end
      end else if (pattern_done && pattern_len != 0) begin
         recent_text.push_front(c);
         if (recent_text.size() > MAX_PATTERN) begin
            void'(recent_text.pop_back());
         end
         if (text_seen < COUNT_CAP) begin
            text_seen++;
         end
         hit = (text_seen >= pattern_len);
         for (int j = 0; hit && j < pattern_len; j++) begin
            if (recent_text[pattern_len - 1 - j] != pattern_chars[j]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            start = text_seen - pattern_len + 1;
            if (start > POS_MAX) begin
               start = POS_MAX;
            end
            run_hit = 1'b1;
            expected_hits.push_back(search_hit_type'{KIND_MATCH, start[POS_W-1:0], fin});
         end else if (fin && !run_hit) begin
            expected_hits.push_back(search_hit_type'{KIND_NONE, '0, 1'b1});
         end
         // end of run: the pattern stays loaded for the next text
         if (fin) begin
            text_seen = 0;
            run_hit   = 1'b0;
         end
      end
   endtask

   // Check responses first: a response at this edge belongs to an earlier request
   always @(posedge clock) begin
      search_hit_type got;
      search_hit_type want;
      if (reset) begin
         pattern_len  = 0;
         pattern_done = 1'b0;
         text_seen    = 0;
         run_hit      = 1'b0;
         error_count  = 0;
         recent_text.delete();
         expected_hits.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = search_hit_type'{rsp_mon.kind, rsp_mon.position, rsp_mon.end_of_run};
            if (expected_hits.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response: expected none, actual kind %0b pos %0d eor %0b",
                        $time, got.kind, got.position, got.end_of_run);
            end else begin
               want = expected_hits.pop_front();
               if (got.kind !== want.kind) begin
                  error_count++;
                  $display("%0t: kind mismatch: expected %0b, actual %0b",
                           $time, want.kind, got.kind);
               end
               if (got.position !== want.position) begin
                  error_count++;
                  $display("%0t: position mismatch: expected %0d, actual %0d",
                           $time, want.position, got.position);
               end
               if (got.end_of_run !== want.end_of_run) begin
                  error_count++;
                  $display("%0t: end_of_run mismatch: expected %0b, actual %0b",
                           $time, want.end_of_run, got.end_of_run);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            search_step(req_mon.req_type, req_mon.ch, req_mon.last);
         end
      end
      pending = expected_hits.size();
   end

endmodule

>>> dv/case_folded_substring_search_tb.sv
`timescale 1ns / 1ps
// Top of the substring search testbench: clock, reset, request and response
// traffic with random gaps, and the verdict. Depends on cfss_pkg, cfss_if,
// the block itself and cfss_search_checker.
module case_folded_substring_search_tb;
   import cfss_pkg::*;

   localparam int MAX_PATTERN  = 256;
   localparam int ITEMS_TARGET = 1350;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset;
   int   sent;
   bit   steady_tx;
   int   failures;
   int   outstanding;

   cfss_req_if req_if ();
   cfss_rsp_if rsp_if ();

   case_folded_substring_search #(.MAX_PATTERN(MAX_PATTERN)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   cfss_search_checker #(.MAX_PATTERN(MAX_PATTERN)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .error_count (failures),
      .pending     (outstanding)
   );

   always #10 clock = ~clock;

   // Mostly a two-letter alphabet in both cases, so that matches are frequent
   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c = 8'("a") + 8'($urandom_range(0, 1));
         4, 5, 6, 7: c = 8'("A") + 8'($urandom_range(0, 1));
         default:    c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   // Offer one request transaction after a random gap and hold it until taken
   task automatic send_char(input logic kind, input logic [7:0] c, input logic fin);
      int gap;
      gap = steady_tx ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= kind;
      req_if.ch       <= c;
      req_if.last     <= fin;
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   task automatic send_run(input logic kind, input int len, input bit close);
      for (int i = 0; i < len; i++) begin
         send_char(kind, pick_char(), close && (i == len - 1));
      end
   endtask

   // Response side: random stalls, stall-free stretches and one long hold-off
   initial begin
      int stall;
      int taken;
      bit held;
      bit steady_rx;
      taken     = 0;
      held      = 1'b0;
      steady_rx = 1'b0;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (taken % 40 == 0) begin
            steady_rx = ($urandom_range(0, 3) == 0);
         end
         stall = steady_rx ? 0 : $urandom_range(0, 11);
         // hold off long enough for the block to fill and stall its input
         if (!held && taken == 30) begin
            stall = 400;
            held  = 1'b1;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         taken++;
      end
   end

   // Request side and verdict
   initial begin
      logic [7:0] long_pat [MAX_PATTERN + 4];
      bit         long_done;
      sent      = 0;
      steady_tx = 1'b0;
      long_done = 1'b0;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.req_type <= REQ_PATTERN;
      req_if.ch       <= 8'h00;
      req_if.last     <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // text before any pattern is closed: ignored
      send_char(REQ_TEXT, "A", 1'b0);
      send_char(REQ_TEXT, "x", 1'b1);
      // pattern "aB" folds to "AB"; text "AbaB" matches twice, the second on last
      send_char(REQ_PATTERN, "a", 1'b0);
      send_char(REQ_PATTERN, "B", 1'b1);
      send_char(REQ_TEXT, "A", 1'b0);
      send_char(REQ_TEXT, "b", 1'b0);
      send_char(REQ_TEXT, "a", 1'b0);
      send_char(REQ_TEXT, "B", 1'b1);
      // a run with no occurrence
      send_char(REQ_TEXT, "z", 1'b1);
      // byte extremes, the byte just below the lower-case letters, and z
      send_char(REQ_PATTERN, 8'h00, 1'b0);
      send_char(REQ_PATTERN, 8'hFF, 1'b0);
      send_char(REQ_PATTERN, 8'h60, 1'b0);
      send_char(REQ_PATTERN, "z", 1'b1);
      send_char(REQ_TEXT, 8'h00, 1'b0);
      send_char(REQ_TEXT, 8'hFF, 1'b0);
      send_char(REQ_TEXT, 8'h60, 1'b0);
      send_char(REQ_TEXT, "Z", 1'b1);
      // a new pattern abandons the run in progress
      send_char(REQ_TEXT, 8'h7B, 1'b0);
      send_char(REQ_PATTERN, "a", 1'b1);
      // overlapping matches, then a final character after earlier matches
      send_char(REQ_TEXT, "a", 1'b0);
      send_char(REQ_TEXT, "A", 1'b0);
      send_char(REQ_TEXT, "b", 1'b0);
      send_char(REQ_TEXT, "b", 1'b1);

      // random sequences, mostly well formed
      while (sent < ITEMS_TARGET) begin
         steady_tx = ($urandom_range(0, 3) == 0);
         if (!long_done && sent > ITEMS_TARGET / 3) begin
            // pattern longer than the store: the excess is dropped
            long_done = 1'b1;
            for (int i = 0; i < MAX_PATTERN + 4; i++) begin
               long_pat[i] = pick_char();
               send_char(REQ_PATTERN, long_pat[i], i == MAX_PATTERN + 3);
            end
            send_run(REQ_TEXT, 3, 1'b0);
            for (int i = 0; i < MAX_PATTERN; i++) begin
               send_char(REQ_TEXT, long_pat[i], 1'b0);
            end
            send_char(REQ_TEXT, "x", 1'b1);
            send_run(REQ_TEXT, 5, 1'b1);
         end else begin
            case ($urandom_range(0, 9))
               7: begin
                  // open pattern, ignored text, then close and search
                  send_run(REQ_PATTERN, $urandom_range(1, 3), 1'b0);
                  send_run(REQ_TEXT, $urandom_range(1, 4), 1'b1);
                  send_run(REQ_PATTERN, 1, 1'b1);
                  send_run(REQ_TEXT, $urandom_range(1, 20), 1'b1);
               end
               8: begin
                  // run left open for the next pattern to cut short
                  send_run(REQ_PATTERN, $urandom_range(1, 3), 1'b1);
                  send_run(REQ_TEXT, $urandom_range(1, 12), 1'b0);
               end
               9: begin
                  repeat ($urandom_range(1, 8)) begin
                     send_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
                  end
               end
               default: begin
                  send_run(REQ_PATTERN, $urandom_range(1, 4), 1'b1);
                  repeat ($urandom_range(1, 3)) begin
                     send_run(REQ_TEXT, $urandom_range(1, 30), 1'b1);
                  end
               end
            endcase
         end
      end
      req_if.valid <= 1'b0;

      // let the last request reach the checker, then drain every response
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
